>>> design/skit_pkg.sv
// ----------------------------------------------------------------------------
// skit_pkg: shared types and codes for the sorted key index table
// Entry layout, action and status codes, and the command and flag groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package skit_pkg;

  // Default table depth.
  localparam int CAPACITY_DEF = 1024;

  // Field widths.
  localparam int KEY_W    = 21;
  localparam int DIM_W    = 16;
  localparam int WORD_W   = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DIM_W-1:0]  glyph_width;
    logic [DIM_W-1:0]  glyph_height;
    logic [WORD_W-1:0] bitmap_offset;
    logic [WORD_W-1:0] bitmap_size;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_item;
    logic                clear_count;
    logic                init_search;
    logic                rd_mid;
    logic                step;
    logic                rd_pos;
    logic                init_shift;
    logic                rd_shift;
    logic                wr_shift;
    logic                wr_new;
    logic                load_out;
    logic [STATUS_W-1:0] out_status;
    logic                out_found;
  } cmd_t;

  // Flags from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic lo_lt_hi;
    logic pos_lt_count;
    logic key_equal;
    logic shift_more;
  } flags_t;

endpackage

>>> design/skit_if.sv
// ----------------------------------------------------------------------------
// skit_if: item channels of the sorted key index table
// The request channel carries one action and its entry fields; the
// response channel carries one result per request.
// ----------------------------------------------------------------------------
interface skit_in_if;
  logic                           valid;
  logic                           ready;
  logic [skit_pkg::ACTION_W-1:0]  action;
  logic [skit_pkg::KEY_W-1:0]     key;
  logic [skit_pkg::DIM_W-1:0]     glyph_width;
  logic [skit_pkg::DIM_W-1:0]     glyph_height;
  logic [skit_pkg::WORD_W-1:0]    bitmap_offset;
  logic [skit_pkg::WORD_W-1:0]    bitmap_size;

  modport source (output valid, action, key, glyph_width, glyph_height,
                  bitmap_offset, bitmap_size, input ready);
  modport sink   (input valid, action, key, glyph_width, glyph_height,
                  bitmap_offset, bitmap_size, output ready);
endinterface

interface skit_out_if;
  logic                           valid;
  logic                           ready;
  logic [skit_pkg::STATUS_W-1:0]  status;
  logic [skit_pkg::DIM_W-1:0]     found_width;
  logic [skit_pkg::DIM_W-1:0]     found_height;
  logic [skit_pkg::WORD_W-1:0]    found_offset;
  logic [skit_pkg::WORD_W-1:0]    found_size;
  logic [skit_pkg::COUNT_W-1:0]   count_now;

  modport source (output valid, status, found_width, found_height,
                  found_offset, found_size, count_now, input ready);
  modport sink   (input valid, status, found_width, found_height,
                  found_offset, found_size, count_now, output ready);
endinterface

>>> design/skit_datapath.sv
// ----------------------------------------------------------------------------
// skit_datapath: entry memory, search bounds and result register
// Holds the sorted entry memory with one write and one registered read
// port, the binary search bounds, the shift index, the entry count and
// the response payload register.
// ----------------------------------------------------------------------------
module skit_datapath #(
  parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  skit_pkg::cmd_t                 cmd,
  output skit_pkg::flags_t               flags,
  input  logic [skit_pkg::KEY_W-1:0]     key,
  input  logic [skit_pkg::DIM_W-1:0]     glyph_width,
  input  logic [skit_pkg::DIM_W-1:0]     glyph_height,
  input  logic [skit_pkg::WORD_W-1:0]    bitmap_offset,
  input  logic [skit_pkg::WORD_W-1:0]    bitmap_size,
  output logic [skit_pkg::STATUS_W-1:0]  status,
  output logic [skit_pkg::DIM_W-1:0]     found_width,
  output logic [skit_pkg::DIM_W-1:0]     found_height,
  output logic [skit_pkg::WORD_W-1:0]    found_offset,
  output logic [skit_pkg::WORD_W-1:0]    found_size,
  output logic [skit_pkg::COUNT_W-1:0]   count_now
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  skit_pkg::entry_t mem [CAPACITY];
  skit_pkg::entry_t item;
  skit_pkg::entry_t rdata;

  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] idx;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] idx_prev;
  logic [CW-1:0] rd_sel;
  logic [CW-1:0] wr_sel;
  logic [31:0]   count_wide;
  logic          mem_re;
  logic          mem_we;
  skit_pkg::entry_t wr_data;

  // Midpoint of the current search window.
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign idx_prev = idx - CW'(1);

  // Read and write address selection.
  assign mem_re  = cmd.rd_mid | cmd.rd_pos | cmd.rd_shift;
  assign mem_we  = cmd.wr_shift | cmd.wr_new;
  assign wr_data = cmd.wr_shift ? rdata : item;
  assign wr_sel  = cmd.wr_shift ? idx : lo;

  always_comb begin
    if (cmd.rd_mid) begin
      rd_sel = mid_calc;
    end else if (cmd.rd_shift) begin
      rd_sel = idx_prev;
    end else begin
      rd_sel = lo;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_sel[AW-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rdata <= mem[rd_sel[AW-1:0]];
    end
  end

  // Latched request fields.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item.key           <= key;
      item.glyph_width   <= glyph_width;
      item.glyph_height  <= glyph_height;
      item.bitmap_offset <= bitmap_offset;
      item.bitmap_size   <= bitmap_size;
    end
  end

  // Search bounds and shift index.
  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.step) begin
      if (rdata.key < item.key) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.rd_mid) begin
      mid <= mid_calc;
    end
    if (cmd.init_shift) begin
      idx <= count;
    end else if (cmd.wr_shift) begin
      idx <= idx_prev;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.wr_new) begin
      count <= count + CW'(1);
    end
  end

  // Flags for the controller.
  assign flags.full         = (count == CW'(CAPACITY));
  assign flags.lo_lt_hi     = (lo < hi);
  assign flags.pos_lt_count = (lo < count);
  assign flags.key_equal    = (rdata.key == item.key);
  assign flags.shift_more   = (idx > lo);

  // Response payload register.
  assign count_wide = 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status    <= cmd.out_status;
      count_now <= count_wide[skit_pkg::COUNT_W-1:0];
      if (cmd.out_found) begin
        found_width  <= rdata.glyph_width;
        found_height <= rdata.glyph_height;
        found_offset <= rdata.bitmap_offset;
        found_size   <= rdata.bitmap_size;
      end else begin
        found_width  <= '0;
        found_height <= '0;
        found_offset <= '0;
        found_size   <= '0;
      end
    end
  end

endmodule

>>> design/skit_controller.sv
// ----------------------------------------------------------------------------
// skit_controller: sequencer for insert, search and clear
// Steps the binary search one memory read at a time, checks the found
// slot, moves later entries up for an insert and hands over the result.
// ----------------------------------------------------------------------------
module skit_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic [skit_pkg::ACTION_W-1:0]  req_action,
  output logic                           req_ready,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  skit_pkg::flags_t               flags,
  output skit_pkg::cmd_t                 cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_FINISH
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic                          is_insert;
  logic                          is_insert_next;
  logic [skit_pkg::STATUS_W-1:0] res_status;
  logic [skit_pkg::STATUS_W-1:0] res_status_next;
  logic                          res_found;
  logic                          res_found_next;
  logic                          rsp_valid_next;
  logic                          accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid & req_ready;

  // Next state and commands.
  always_comb begin
    state_next      = state;
    is_insert_next  = is_insert;
    res_status_next = res_status;
    res_found_next  = res_found;
    rsp_valid_next  = rsp_valid & ~rsp_ready;
    cmd             = '0;
    cmd.out_status  = res_status;
    cmd.out_found   = res_found;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item   = 1'b1;
          res_found_next  = 1'b0;
          res_status_next = skit_pkg::ST_OK;
          is_insert_next  = (req_action == skit_pkg::ACT_INSERT);
          state_next      = S_FINISH;
          case (req_action)
            skit_pkg::ACT_INSERT: begin
              if (flags.full) begin
                res_status_next = skit_pkg::ST_FULL;
              end else begin
                cmd.init_search = 1'b1;
                state_next      = S_SRCH_RD;
              end
            end
            skit_pkg::ACT_SEARCH: begin
              cmd.init_search = 1'b1;
              state_next      = S_SRCH_RD;
            end
            skit_pkg::ACT_CLEAR: begin
              cmd.clear_count = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        if (flags.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = S_SRCH_CMP;
        end else if (flags.pos_lt_count) begin
          cmd.rd_pos = 1'b1;
          state_next = S_CHECK;
        end else if (is_insert) begin
          // Key goes past the last entry: nothing to move.
          state_next = S_INSERT;
        end else begin
          res_status_next = skit_pkg::ST_MISS;
          state_next      = S_FINISH;
        end
      end
      S_SRCH_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_SRCH_RD;
      end
      S_CHECK: begin
        if (flags.key_equal) begin
          if (is_insert) begin
            res_status_next = skit_pkg::ST_DUP;
          end else begin
            res_found_next = 1'b1;
          end
          state_next = S_FINISH;
        end else if (is_insert) begin
          cmd.init_shift = 1'b1;
          state_next     = S_SHIFT_RD;
        end else begin
          res_status_next = skit_pkg::ST_MISS;
          state_next      = S_FINISH;
        end
      end
      S_SHIFT_RD: begin
        if (flags.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd.wr_new = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hand the result over once the response register is free.
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      is_insert  <= 1'b0;
      res_status <= skit_pkg::ST_OK;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      rsp_valid  <= rsp_valid_next;
      is_insert  <= is_insert_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

endmodule

>>> design/sorted_key_index_table.sv
// Search: a read and a compare state per halving of the window, then a check of the
// found slot. Insert in the middle: as a search, then a read and a write per entry
// moved up; an append past the last key skips the check and the move. Clear, the
// unused action and an insert into a full table go straight to the hand-over. One
// item is in work at a time; the next is taken once the controller is idle again.
// Reset clears the entry count and the control state; the memory is not swept.
// ----------------------------------------------------------------------------
// sorted_key_index_table: sorted key table with binary search and insert
// Keeps up to CAPACITY entries in ascending key order and answers insert,
// search and clear requests, one result item per request item.
// ----------------------------------------------------------------------------
module sorted_key_index_table #(
  parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  skit_in_if.sink   req,
  skit_out_if.source rsp
);

  skit_pkg::cmd_t   cmd;
  skit_pkg::flags_t flags;

  // Sequencer.
  skit_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .flags      (flags),
    .cmd        (cmd)
  );

  // Memory, bounds and result register.
  skit_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .key           (req.key),
    .glyph_width   (req.glyph_width),
    .glyph_height  (req.glyph_height),
    .bitmap_offset (req.bitmap_offset),
    .bitmap_size   (req.bitmap_size),
    .status        (rsp.status),
    .found_width   (rsp.found_width),
    .found_height  (rsp.found_height),
    .found_offset  (rsp.found_offset),
    .found_size    (rsp.found_size),
    .count_now     (rsp.count_now)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted key index table
// A queue of insert, search and clear items feeds a clocked driver, and a
// clocked monitor checks every result item against a shadow copy of the
// table that is updated as each request item is accepted.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          TABLE_DEPTH    = skit_pkg::CAPACITY_DEF;
  localparam int unsigned KEY_MAX        = 32'h10FFFF;
  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam logic [skit_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum int {PAY_RANDOM, PAY_ZERO, PAY_ONES} payload_kind_t;

  // One request item as queued for the driver.
  typedef struct {
    logic [skit_pkg::ACTION_W-1:0] action;
    logic [skit_pkg::KEY_W-1:0]    key;
    logic [skit_pkg::DIM_W-1:0]    glyph_width;
    logic [skit_pkg::DIM_W-1:0]    glyph_height;
    logic [skit_pkg::WORD_W-1:0]   bitmap_offset;
    logic [skit_pkg::WORD_W-1:0]   bitmap_size;
    bit                            wait_drained;
  } glyph_request_t;

  // One result item as the block should return it.
  typedef struct packed {
    logic [skit_pkg::STATUS_W-1:0] status;
    logic [skit_pkg::DIM_W-1:0]    found_width;
    logic [skit_pkg::DIM_W-1:0]    found_height;
    logic [skit_pkg::WORD_W-1:0]   found_offset;
    logic [skit_pkg::WORD_W-1:0]   found_size;
    logic [skit_pkg::COUNT_W-1:0]  count_now;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst;

  skit_in_if  req_ch ();
  skit_out_if rsp_ch ();

  sorted_key_index_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  glyph_request_t glyph_requests_pending[$];
  lookup_result_t expected_lookups[$];
  glyph_request_t presented;
  int unsigned    failures = 0;
  int unsigned    gap_left;
  int unsigned    stall_left;
  int unsigned    idle_cycles;
  int unsigned    cycle_count;

  // Idling is switched off for one stretch out of every three.
  wire quiet_phase = ((cycle_count / 3000) % 3) == 1;

  // Shadow of the table contents and the entry count.
  skit_pkg::entry_t shadow_table[TABLE_DEPTH];
  int               shadow_count = 0;

  // Key set as the stimulus generator expects it to be.
  bit          gen_present[int unsigned];
  int unsigned gen_keys[$];
  int unsigned real_items = 0;

  // First slot whose key is not below k, in 0 to shadow_count.
  function automatic int first_slot_at_or_above(input logic [skit_pkg::KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_table[mid].key < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request to the shadow table and returns its result.
  function automatic lookup_result_t apply_request(input glyph_request_t r);
    lookup_result_t res;
    int             slot;
    res = '0;
    res.status = skit_pkg::ST_OK;
    case (r.action)
      skit_pkg::ACT_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          res.status = skit_pkg::ST_FULL;
        end else begin
          slot = first_slot_at_or_above(r.key);
          if (slot < shadow_count && shadow_table[slot].key == r.key) begin
            res.status = skit_pkg::ST_DUP;
          end else begin
            for (int i = shadow_count; i > slot; i--) shadow_table[i] = shadow_table[i-1];
            shadow_table[slot] = '{key: r.key, glyph_width: r.glyph_width,
                                   glyph_height: r.glyph_height,
                                   bitmap_offset: r.bitmap_offset,
                                   bitmap_size: r.bitmap_size};
            shadow_count++;
          end
        end
      end
      skit_pkg::ACT_SEARCH: begin
        slot = first_slot_at_or_above(r.key);
        if (slot < shadow_count && shadow_table[slot].key == r.key) begin
          res.found_width  = shadow_table[slot].glyph_width;
          res.found_height = shadow_table[slot].glyph_height;
          res.found_offset = shadow_table[slot].bitmap_offset;
          res.found_size   = shadow_table[slot].bitmap_size;
        end else begin
          res.status = skit_pkg::ST_MISS;
        end
      end
      skit_pkg::ACT_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.count_now = shadow_count[skit_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned fresh_key();
    return $urandom_range(0, KEY_MAX);
  endfunction

  function automatic int unsigned present_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  // Queues one request item and tracks which keys the table should hold.
  task automatic queue_item(input logic [skit_pkg::ACTION_W-1:0] act, input int unsigned k,
                            input payload_kind_t pay, input bit drained);
    glyph_request_t r;
    r.action        = act;
    r.key           = k[skit_pkg::KEY_W-1:0];
    r.glyph_width   = skit_pkg::DIM_W'($urandom());
    r.glyph_height  = skit_pkg::DIM_W'($urandom());
    r.bitmap_offset = $urandom();
    r.bitmap_size   = $urandom();
    r.wait_drained  = drained;
    if (pay == PAY_ZERO) begin
      r.glyph_width   = '0;
      r.glyph_height  = '0;
      r.bitmap_offset = '0;
      r.bitmap_size   = '0;
    end else if (pay == PAY_ONES) begin
      r.glyph_width   = '1;
      r.glyph_height  = '1;
      r.bitmap_offset = '1;
      r.bitmap_size   = '1;
    end
    if (act == skit_pkg::ACT_INSERT && gen_keys.size() < TABLE_DEPTH &&
        !gen_present.exists(k)) begin
      gen_present[k] = 1'b1;
      gen_keys.push_back(k);
    end else if (act == skit_pkg::ACT_CLEAR) begin
      gen_present.delete();
      gen_keys.delete();
    end
    if (act != ACT_UNUSED) real_items++;
    glyph_requests_pending.push_back(r);
  endtask

  // Request driver: holds an item until it is taken, then idles a while.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_lookups.push_back(apply_request(presented));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          req_ch.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (glyph_requests_pending.size() != 0 &&
                     !(glyph_requests_pending[0].wait_drained &&
                       expected_lookups.size() != 0)) begin
          presented = glyph_requests_pending.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.action        <= presented.action;
          req_ch.key           <= presented.key;
          req_ch.glyph_width   <= presented.glyph_width;
          req_ch.glyph_height  <= presented.glyph_height;
          req_ch.bitmap_offset <= presented.bitmap_offset;
          req_ch.bitmap_size   <= presented.bitmap_size;
          gap_left             <= quiet_phase ? 0 : pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls on ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Result monitor: each result item is checked against the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, rsp_ch.status, rsp_ch.count_now);
        failures++;
      end else begin
        want = expected_lookups.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("found_width", want.found_width, rsp_ch.found_width);
        check_field("found_height", want.found_height, rsp_ch.found_height);
        check_field("found_offset", want.found_offset, rsp_ch.found_offset);
        check_field("found_size", want.found_size, rsp_ch.found_size);
        check_field("count_now", want.count_now, rsp_ch.count_now);
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned directed_items;
    int unsigned target;
    int unsigned ops;
    int unsigned roll;
    int unsigned k;
    bit          filled;

    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.action        = skit_pkg::ACT_INSERT;
    req_ch.key           = '0;
    req_ch.glyph_width   = '0;
    req_ch.glyph_height  = '0;
    req_ch.bitmap_offset = '0;
    req_ch.bitmap_size   = '0;
    rsp_ch.ready         = 1'b0;
    cycle_count          = 0;
    idle_cycles          = 0;
    filled               = 1'b0;

    // Directed: empty table, unused action, extreme keys and payloads,
    // front and middle inserts, duplicates, hits, misses and clears.
    queue_item(skit_pkg::ACT_SEARCH, 0, PAY_RANDOM, 1'b0);
    queue_item(ACT_UNUSED, KEY_MAX, PAY_ONES, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, KEY_MAX, PAY_ONES, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, 0, PAY_ZERO, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, 32'h80000, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, KEY_MAX, PAY_ZERO, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, 0, PAY_ONES, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, KEY_MAX, PAY_ZERO, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, 0, PAY_ONES, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, 32'h80000, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, 5, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, KEY_MAX - 1, PAY_RANDOM, 1'b0);
    queue_item(ACT_UNUSED, 0, PAY_ZERO, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, KEY_MAX - 1, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, KEY_MAX - 1, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_CLEAR, KEY_MAX, PAY_ONES, 1'b0);
    queue_item(skit_pkg::ACT_SEARCH, 0, PAY_RANDOM, 1'b0);
    queue_item(skit_pkg::ACT_CLEAR, 0, PAY_ZERO, 1'b0);
    queue_item(skit_pkg::ACT_INSERT, 7, PAY_RANDOM, 1'b1);
    queue_item(skit_pkg::ACT_SEARCH, 7, PAY_RANDOM, 1'b0);
    directed_items = real_items;

    // Random part: short table lifetimes of mixed operations, with one
    // lifetime that fills the table to capacity.
    while (real_items - directed_items < RANDOM_ITEMS) begin
      if (!filled && real_items - directed_items >= 400) begin
        filled = 1'b1;
        queue_item(skit_pkg::ACT_CLEAR, fresh_key(), PAY_RANDOM, 1'b0);
        k = $urandom_range(1, 64);
        for (int n = 0; n < TABLE_DEPTH - 1; n++) begin
          queue_item(skit_pkg::ACT_INSERT, k, PAY_RANDOM, 1'b0);
          if ($urandom_range(0, 49) == 0)
            queue_item(skit_pkg::ACT_SEARCH, present_key(), PAY_RANDOM, 1'b0);
          k += $urandom_range(1, 1000);
        end
        // Front insert moves every entry up and fills the last slot.
        queue_item(skit_pkg::ACT_INSERT, 0, PAY_RANDOM, 1'b1);
        queue_item(skit_pkg::ACT_INSERT, KEY_MAX, PAY_RANDOM, 1'b0);
        queue_item(skit_pkg::ACT_INSERT, 0, PAY_RANDOM, 1'b0);
        queue_item(skit_pkg::ACT_INSERT, present_key(), PAY_RANDOM, 1'b0);
        for (int n = 0; n < 25; n++) begin
          if (n % 5 == 0) queue_item(skit_pkg::ACT_SEARCH, fresh_key(), PAY_RANDOM, 1'b0);
          else queue_item(skit_pkg::ACT_SEARCH, present_key(), PAY_RANDOM, 1'b0);
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 85) target = $urandom_range(1, 24);
        else if (roll < 97) target = $urandom_range(40, 100);
        else target = $urandom_range(150, 250);
        ops = 2 * target + $urandom_range(2, 10);
        if ($urandom_range(0, 4) != 0)
          queue_item(skit_pkg::ACT_CLEAR, fresh_key(), PAY_RANDOM,
                     $urandom_range(0, 9) == 0);
        for (int n = 0; n < ops; n++) begin
          roll = $urandom_range(0, 99);
          if (roll < 45 && gen_keys.size() < target)
            queue_item(skit_pkg::ACT_INSERT, fresh_key(), PAY_RANDOM, 1'b0);
          else if (roll < 52 && gen_keys.size() != 0)
            queue_item(skit_pkg::ACT_INSERT, present_key(), PAY_RANDOM, 1'b0);
          else if (roll < 82 && gen_keys.size() != 0)
            queue_item(skit_pkg::ACT_SEARCH, present_key(), PAY_RANDOM, 1'b0);
          else if (roll >= 95 && roll < 98)
            queue_item(ACT_UNUSED, fresh_key(), PAY_RANDOM, 1'b0);
          else if (roll >= 98)
            queue_item(skit_pkg::ACT_CLEAR, fresh_key(), PAY_RANDOM, 1'b0);
          else
            queue_item(skit_pkg::ACT_SEARCH, fresh_key(), PAY_RANDOM, 1'b0);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to go in and every result to come back.
    while (glyph_requests_pending.size() != 0 || req_ch.valid ||
           expected_lookups.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
